@@ hw/rtl/vfd_pkg.sv @@
// Shared types, constants and decode tables of the four-tube display scan driver.
// No dependencies; vfd_bcd_split, vfd_display, the top level and the testbench import this package.
package vfd_pkg;

  localparam int NUM_TUBES = 4;
  localparam int TUBE_W    = 2;
  localparam int DIGITS    = 4;

  localparam logic [7:0] SPACE_CODE  = 8'h20;
  localparam logic [4:0] BLANK_INDEX = 5'd31;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_CASE_OFS = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] RAW_MAX   = 8'd9;

  localparam logic [4:0] IDX_DASH    = 5'd29;
  localparam logic [4:0] IDX_LESS    = 5'd26;
  localparam logic [4:0] IDX_GREATER = 5'd30;

  localparam logic [16:0] TEN_THOUSAND = 17'd10000;
  localparam logic [16:0] THOUSAND     = 17'd1000;
  localparam logic [16:0] HUNDRED      = 17'd100;
  localparam logic [16:0] TEN          = 17'd10;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CHAR   = 3'd1,
    OP_NUMBER = 3'd2,
    OP_DOT    = 3'd3,
    OP_LEDS   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  position;
    logic [7:0]  char_code;
    logic        left_justify;
    logic        flag;
    logic        lt10;
    logic        lt100;
    logic        lt1000;
  } cmd_t;

  typedef struct packed {
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } digits_t;

  typedef struct packed {
    logic [6:0]        segments;
    logic              dot;
    logic              led;
    logic [TUBE_W-1:0] tube;
  } res_t;

  localparam logic [6:0] SEG_TABLE [32] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70,
    7'h7F, 7'h7B, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47,
    7'h37, 7'h3C, 7'h0E, 7'h54, 7'h15, 7'h67, 7'h73, 7'h05,
    7'h0F, 7'h3E, 7'h1C, 7'h2A, 7'h3B, 7'h01, 7'h62, 7'h00
  };

  // pattern index for letters a..z
  localparam logic [4:0] LETTER_INDEX [26] = '{
    5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd9,  5'd16, 5'd1,
    5'd17, 5'd16, 5'd18, 5'd19, 5'd20, 5'd0,  5'd21, 5'd22, 5'd23,
    5'd5,  5'd24, 5'd25, 5'd26, 5'd27, 5'd16, 5'd28, 5'd2
  };

  function automatic logic [4:0] decode_index(logic [7:0] c);
    logic [7:0] lc;
    logic [4:0] idx;
    lc  = c;
    idx = BLANK_INDEX;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) lc = c + CH_CASE_OFS;
    priority if (c <= RAW_MAX) idx = c[4:0];
    else if (c >= CH_ZERO && c <= CH_NINE) idx = 5'(c - CH_ZERO);
    else if (lc >= CH_LOWER_A && lc <= CH_LOWER_Z) idx = LETTER_INDEX[5'(lc - CH_LOWER_A)];
    else if (c == CH_DASH) idx = IDX_DASH;
    else if (c == CH_LESS) idx = IDX_LESS;
    else if (c == CH_GREATER) idx = IDX_GREATER;
    else idx = BLANK_INDEX;
    return idx;
  endfunction

  // leading decimal digit of value in units of unit (value < 10 * unit);
  // unit is a constant at every call, so the compares run in parallel
  function automatic logic [3:0] dec_digit(logic [16:0] value, logic [16:0] unit);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({4'b0, value} >= 21'(k) * {4'b0, unit}) d = 4'(k);
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/vfd_if.sv @@
// Valid/ready channel interfaces of the display scan driver: command input and scan result.
// Standalone; widths follow the package field definitions.
interface vfd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [1:0]  position;
  logic [7:0]  char_code;
  logic [15:0] number;
  logic        left_justify;
  logic        flag;

  modport source (output valid, op, position, char_code, number, left_justify, flag,
                  input ready);
  modport sink (input valid, op, position, char_code, number, left_justify, flag,
                output ready);
endinterface

interface vfd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] segments;
  logic       dot_out;
  logic       led_out;
  logic [1:0] tube;

  modport source (output valid, segments, dot_out, led_out, tube, input ready);
  modport sink (input valid, segments, dot_out, led_out, tube, output ready);
endinterface

@@ hw/rtl/vfd_bcd_split.sv @@
// Four-stage decimal digit extraction pipeline; every command flows through it in order.
// Depends on vfd_pkg (cmd_t, digits_t, dec_digit).
module vfd_bcd_split
  import vfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  cmd_t        in_cmd,
  input  logic [15:0] in_number,
  output logic        out_valid,
  output cmd_t        out_cmd,
  output digits_t     out_digits
);

  logic        s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  cmd_t        s1_cmd_r, s2_cmd_r, s3_cmd_r, s4_cmd_r;
  logic [13:0] s1_rem_r;
  logic [9:0]  s2_rem_r;
  logic [6:0]  s3_rem_r;
  logic [3:0]  s2_d3_r, s3_d3_r, s3_d2_r;
  digits_t     s4_dig_r;

  logic [3:0]  d4, d3, d2, d1;
  logic [16:0] rem1, rem2, rem3, rem4;
  cmd_t        s1_cmd_nxt;

  always_comb begin
    s1_cmd_nxt        = in_cmd;
    s1_cmd_nxt.lt10   = in_number < 16'd10;
    s1_cmd_nxt.lt100  = in_number < 16'd100;
    s1_cmd_nxt.lt1000 = in_number < 16'd1000;
    d4   = dec_digit({1'b0, in_number}, TEN_THOUSAND);
    rem1 = {1'b0, in_number} - 17'(17'(d4) * TEN_THOUSAND);
    d3   = dec_digit(17'(s1_rem_r), THOUSAND);
    rem2 = 17'(s1_rem_r) - 17'(17'(d3) * THOUSAND);
    d2   = dec_digit(17'(s2_rem_r), HUNDRED);
    rem3 = 17'(s2_rem_r) - 17'(17'(d2) * HUNDRED);
    d1   = dec_digit(17'(s3_rem_r), TEN);
    rem4 = 17'(s3_rem_r) - 17'(17'(d1) * TEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r    <= s1_cmd_nxt;
      s1_rem_r    <= rem1[13:0];
      s2_cmd_r    <= s1_cmd_r;
      s2_d3_r     <= d3;
      s2_rem_r    <= rem2[9:0];
      s3_cmd_r    <= s2_cmd_r;
      s3_d3_r     <= s2_d3_r;
      s3_d2_r     <= d2;
      s3_rem_r    <= rem3[6:0];
      s4_cmd_r    <= s3_cmd_r;
      s4_dig_r.d3 <= s3_d3_r;
      s4_dig_r.d2 <= s3_d2_r;
      s4_dig_r.d1 <= d1;
      s4_dig_r.d0 <= rem4[3:0];
    end
  end

  assign out_valid  = s4_valid_r;
  assign out_cmd    = s4_cmd_r;
  assign out_digits = s4_dig_r;

endmodule

@@ hw/rtl/vfd_display.sv @@
// Character, dot and LED stores, scan index, segment decode and result register.
// Depends on vfd_pkg (cmd_t, digits_t, res_t, decode tables).
module vfd_display
  import vfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  input  digits_t digits,
  output logic    res_valid,
  output res_t    res
);

  logic [7:0]           char_r   [NUM_TUBES];
  logic [7:0]           char_nxt [NUM_TUBES];
  logic [NUM_TUBES-1:0] dot_r, dot_nxt;
  logic [NUM_TUBES-1:0] led_r, led_nxt;
  logic [TUBE_W-1:0]    scan_r, scan_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 res_r, res_nxt;

  logic                 apply;
  logic                 is_tick;
  logic [7:0]           nc [DIGITS];
  logic [7:0]           c3, c2, c1, c0;

  assign apply   = adv && cmd_valid;
  assign is_tick = cmd.op == OP_TICK;

  always_comb begin
    c3 = {4'b0, digits.d3};
    c2 = {4'b0, digits.d2};
    c1 = {4'b0, digits.d1};
    c0 = {4'b0, digits.d0};
    if (!cmd.left_justify) begin
      nc[0] = cmd.lt1000 ? SPACE_CODE : c3;
      nc[1] = cmd.lt100 ? SPACE_CODE : c2;
      nc[2] = cmd.lt10 ? SPACE_CODE : c1;
      nc[3] = c0;
    end else begin
      priority if (!cmd.lt1000) begin
        nc[0] = c3; nc[1] = c2; nc[2] = c1; nc[3] = c0;
      end else if (!cmd.lt100) begin
        nc[0] = c2; nc[1] = c1; nc[2] = c0; nc[3] = SPACE_CODE;
      end else if (!cmd.lt10) begin
        nc[0] = c1; nc[1] = c0; nc[2] = SPACE_CODE; nc[3] = SPACE_CODE;
      end else begin
        nc[0] = c0; nc[1] = SPACE_CODE; nc[2] = SPACE_CODE; nc[3] = SPACE_CODE;
      end
    end
  end

  always_comb begin
    char_nxt = char_r;
    dot_nxt  = dot_r;
    led_nxt  = led_r;
    scan_nxt = scan_r;
    if (apply) begin
      unique case (cmd.op)
        OP_TICK: begin
          scan_nxt = (scan_r == TUBE_W'(NUM_TUBES - 1)) ? '0 : scan_r + 1'b1;
        end
        OP_CHAR: begin
          if (32'(cmd.position) < NUM_TUBES) char_nxt[cmd.position] = cmd.char_code;
        end
        OP_NUMBER: begin
          dot_nxt = '0;
          for (int i = 0; i < NUM_TUBES; i++) begin
            char_nxt[i] = (i < DIGITS) ? nc[i] : SPACE_CODE;
          end
        end
        OP_DOT: begin
          if (32'(cmd.position) < NUM_TUBES) dot_nxt[cmd.position] = cmd.flag;
        end
        OP_LEDS: begin
          led_nxt = {NUM_TUBES{cmd.flag}};
        end
        OP_CLEAR: begin
          dot_nxt = '0;
          led_nxt = '0;
          for (int i = 0; i < NUM_TUBES; i++) char_nxt[i] = SPACE_CODE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.segments = SEG_TABLE[decode_index(char_r[scan_nxt])];
    res_nxt.dot      = dot_r[scan_nxt];
    res_nxt.led      = led_r[scan_nxt];
    res_nxt.tube     = scan_nxt;
    out_valid_nxt    = adv ? (apply && is_tick) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TUBES; i++) char_r[i] <= SPACE_CODE;
      dot_r       <= '0;
      led_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      char_r      <= char_nxt;
      dot_r       <= dot_nxt;
      led_r       <= led_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (apply && is_tick) res_r <= res_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

`ifndef ASSERT_OFF
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    apply && is_tick |=> out_valid_r)
    else $error("tick transaction produced no result");

  a_result_tube_matches_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.tube == scan_r)
    else $error("result tube differs from scan index");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !adv |=> out_valid_r && $stable(res_r))
    else $error("stalled result changed");

  a_clear_empties_flags: assert property (@(posedge clk) disable iff (!rst_n)
    apply && cmd.op == OP_CLEAR |=> dot_r == '0 && led_r == '0 && char_r[0] == SPACE_CODE)
    else $error("clear left stored state");
`endif

endmodule

@@ hw/rtl/vfd_four_digit_scan_driver.sv @@
// Top level of the four-tube multiplexed display scan driver.
// Depends on vfd_pkg, vfd_if, vfd_bcd_split and vfd_display.
//
// Takes one command transaction per clock cycle, every cycle, for as long as the result side
// keeps up. Each command runs through a fixed pipeline: the input register, four decimal digit
// stages (one digit per stage) and the store update, where a tick's result is registered;
// writes update the stores at the same point, so ticks always see every earlier write. A result
// waiting at the output stalls the whole pipeline and the input together.
module vfd_four_digit_scan_driver
  import vfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  vfd_in_if.sink    in_chan,
  vfd_out_if.source out_chan
);

  logic        adv;
  logic        r0_valid_r;
  cmd_t        r0_cmd_r, r0_cmd_nxt;
  logic [15:0] r0_num_r;

  logic        s4_valid;
  cmd_t        s4_cmd;
  digits_t     s4_digits;
  logic        res_valid;
  res_t        res;

  assign adv           = !res_valid || out_chan.ready;
  assign in_chan.ready = adv;

  always_comb begin
    r0_cmd_nxt              = '0;
    r0_cmd_nxt.op           = op_t'(in_chan.op);
    r0_cmd_nxt.position     = in_chan.position;
    r0_cmd_nxt.char_code    = in_chan.char_code;
    r0_cmd_nxt.left_justify = in_chan.left_justify;
    r0_cmd_nxt.flag         = in_chan.flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_valid_r <= 1'b0;
    end else if (adv) begin
      r0_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_chan.valid) begin
      r0_cmd_r <= r0_cmd_nxt;
      r0_num_r <= in_chan.number;
    end
  end

  vfd_bcd_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (r0_valid_r),
    .in_cmd     (r0_cmd_r),
    .in_number  (r0_num_r),
    .out_valid  (s4_valid),
    .out_cmd    (s4_cmd),
    .out_digits (s4_digits)
  );

  vfd_display u_display (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cmd_valid (s4_valid),
    .cmd       (s4_cmd),
    .digits    (s4_digits),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_chan.valid    = res_valid;
  assign out_chan.segments = res.segments;
  assign out_chan.dot_out  = res.dot;
  assign out_chan.led_out  = res.led;
  assign out_chan.tube     = res.tube;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench of the four-tube display scan driver: directed and random command
// traffic with an in-bench display model and scan-result checks. Needs vfd_pkg, vfd_if, RTL.
`timescale 1ns / 1ps

module tb_top;
  import vfd_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // segment patterns, entry 0 in the low bits
  localparam logic [32*7-1:0] GLYPH_ROM = {
    7'h00, 7'h62, 7'h01, 7'h3B, 7'h2A, 7'h1C, 7'h3E, 7'h0F,
    7'h05, 7'h73, 7'h67, 7'h15, 7'h54, 7'h0E, 7'h3C, 7'h37,
    7'h47, 7'h4F, 7'h3D, 7'h4E, 7'h1F, 7'h77, 7'h7B, 7'h7F,
    7'h70, 7'h5F, 7'h5B, 7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E
  };
  // glyph index of letters, 'a' in the low bits
  localparam logic [26*5-1:0] LETTER_ROM = {
    5'd2,  5'd28, 5'd16, 5'd27, 5'd26, 5'd25, 5'd24, 5'd5,  5'd23,
    5'd22, 5'd21, 5'd0,  5'd20, 5'd19, 5'd18, 5'd16, 5'd17, 5'd1,
    5'd16, 5'd9,  5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10
  };

  typedef struct packed {
    logic [6:0] segments;
    logic       dot;
    logic       led;
    logic [1:0] tube;
  } scan_t;

  logic clk;
  logic rst_n;

  vfd_in_if  in_chan ();
  vfd_out_if out_chan ();

  vfd_four_digit_scan_driver uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  logic [7:0] char_mem [NUM_TUBES];
  logic       dot_mem  [NUM_TUBES];
  logic       led_mem  [NUM_TUBES];
  logic [1:0] scan_pos;

  scan_t pending_scans [$];

  int err_count;
  int cmd_count;
  int scan_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [6:0] glyph_of(logic [7:0] code);
    logic [7:0] c;
    logic [4:0] idx;
    c = code;
    if (code <= 8'd9) begin
      idx = code[4:0];
    end else if (code >= CH_ZERO && code <= CH_ZERO + 8'd9) begin
      idx = 5'(code - CH_ZERO);
    end else begin
      if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25) c = c + 8'd32;
      if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd25)
        idx = LETTER_ROM[int'(c - CH_LOWER_A)*5 +: 5];
      else if (c == CH_DASH) idx = 5'd29;
      else if (c == CH_LESS) idx = 5'd26;
      else if (c == CH_GREATER) idx = 5'd30;
      else idx = 5'd31;
    end
    return GLYPH_ROM[int'(idx)*7 +: 7];
  endfunction

  function automatic void blank_chars();
    for (int i = 0; i < NUM_TUBES; i++) begin
      char_mem[i] = SPACE_CODE;
      dot_mem[i]  = 1'b0;
    end
  endfunction

  function automatic void show_number(int unsigned num, logic left);
    int unsigned v;
    logic [7:0]  d3, d2, d1, d0;
    v  = num % 10000;
    d3 = 8'(v / 1000);
    d2 = 8'((v / 100) % 10);
    d1 = 8'((v / 10) % 10);
    d0 = 8'(v % 10);
    blank_chars();
    if (!left) begin
      char_mem[0] = (num < 1000) ? SPACE_CODE : d3;
      char_mem[1] = (num < 100) ? SPACE_CODE : d2;
      char_mem[2] = (num < 10) ? SPACE_CODE : d1;
      char_mem[3] = d0;
    end else if (num >= 1000) begin
      char_mem[0] = d3;
      char_mem[1] = d2;
      char_mem[2] = d1;
      char_mem[3] = d0;
    end else if (num >= 100) begin
      char_mem[0] = d2;
      char_mem[1] = d1;
      char_mem[2] = d0;
    end else if (num >= 10) begin
      char_mem[0] = d1;
      char_mem[1] = d0;
    end else begin
      char_mem[0] = d0;
    end
  endfunction

  function automatic void apply_display_cmd(logic [2:0] op, logic [1:0] pos, logic [7:0] code,
                                            logic [15:0] num, logic left, logic flag);
    scan_t s;
    case (op)
      OP_TICK: begin
        scan_pos   = scan_pos + 2'd1;
        s.segments = glyph_of(char_mem[scan_pos]);
        s.dot      = dot_mem[scan_pos];
        s.led      = led_mem[scan_pos];
        s.tube     = scan_pos;
        pending_scans.push_back(s);
      end
      OP_CHAR:   char_mem[pos] = code;
      OP_NUMBER: show_number(int'(num), left);
      OP_DOT:    dot_mem[pos] = flag;
      OP_LEDS: begin
        for (int i = 0; i < NUM_TUBES; i++) led_mem[i] = flag;
      end
      OP_CLEAR: begin
        blank_chars();
        for (int i = 0; i < NUM_TUBES; i++) led_mem[i] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(logic [2:0] op, logic [1:0] pos = 2'd0, logic [7:0] code = 8'd0,
                          logic [15:0] num = 16'd0, logic left = 1'b0, logic flag = 1'b0);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.op           = op;
    in_chan.position     = pos;
    in_chan.char_code    = code;
    in_chan.number       = num;
    in_chan.left_justify = left;
    in_chan.flag         = flag;
    in_chan.valid        = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    apply_display_cmd(op, pos, code, num, left, flag);
    cmd_count++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_cmd(OP_TICK);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(5))
      0: return 8'($urandom_range(9));
      1: return CH_ZERO + 8'($urandom_range(9));
      2: return CH_UPPER_A + 8'($urandom_range(25));
      3: return CH_LOWER_A + 8'($urandom_range(25));
      4: begin
        case ($urandom_range(2))
          0: return CH_DASH;
          1: return CH_LESS;
          default: return CH_GREATER;
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_number();
    case ($urandom_range(4))
      0: return 16'($urandom_range(9));
      1: return 16'($urandom_range(99, 10));
      2: return 16'($urandom_range(999, 100));
      3: return 16'($urandom_range(9999, 1000));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_random_cmds(int n);
    int         r;
    logic [2:0] op;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 50) op = OP_TICK;
      else if (r < 65) op = OP_CHAR;
      else if (r < 76) op = OP_NUMBER;
      else if (r < 85) op = OP_DOT;
      else if (r < 92) op = OP_LEDS;
      else if (r < 96) op = OP_CLEAR;
      else op = r[0] ? OP_SPARE_7 : OP_SPARE_6;
      send_cmd(op, 2'($urandom_range(3)), pick_code(), pick_number(),
               1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // reset contents, all write ops, out-of-range numbers, ignored op codes
  task automatic test_directed_writes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_ticks(1);
    send_cmd(OP_CHAR, 2'd0, 8'd0);
    send_cmd(OP_CHAR, 2'd1, 8'hFF);
    send_cmd(OP_CHAR, 2'd2, CH_DASH);
    send_cmd(OP_CHAR, 2'd3, CH_UPPER_A + 8'd25);
    send_cmd(OP_DOT, 2'd3, 8'd0, 16'd0, 1'b0, 1'b1);
    send_cmd(OP_LEDS, 2'd0, 8'd0, 16'd0, 1'b0, 1'b1);
    send_ticks(4);
    send_cmd(OP_SPARE_6, 2'd3, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    send_cmd(OP_SPARE_7, 2'd0, 8'd0, 16'd0, 1'b1, 1'b0);
    send_cmd(OP_NUMBER, 2'd0, 8'd0, 16'hFFFF, 1'b0);
    send_ticks(1);
    send_cmd(OP_NUMBER, 2'd0, 8'd0, 16'd12345, 1'b1);
    send_cmd(OP_NUMBER, 2'd0, 8'd0, 16'd7, 1'b0);
    send_cmd(OP_NUMBER, 2'd0, 8'd0, 16'd42, 1'b1);
    send_ticks(2);
    send_cmd(OP_CLEAR);
    send_ticks(2);
  endtask

  task automatic test_slow_receiver();
    send_idle_pct  = 15;
    recv_stall_pct = 75;
    send_random_cmds(620);
  endtask

  task automatic test_slow_sender();
    send_idle_pct  = 75;
    recv_stall_pct = 15;
    send_random_cmds(620);
  endtask

  task automatic test_full_rate();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_cmds(600);
  endtask

  // receiver holds off long enough for the pipeline to fill and back up
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    in_chan.valid = 1'b0;
    hold_left = 300;
    send_ticks(40);
    send_random_cmds(20);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready = 1'b0;
      hold_left--;
    end else begin
      out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    scan_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      scan_count++;
      if (pending_scans.size() == 0) begin
        $error("unexpected scan transaction: tube %0d", out_chan.tube);
        err_count++;
      end else begin
        e = pending_scans.pop_front();
        if (out_chan.segments !== e.segments) begin
          $error("segments: expected %h actual %h", e.segments, out_chan.segments);
          err_count++;
        end
        if (out_chan.dot_out !== e.dot) begin
          $error("dot_out: expected %b actual %b", e.dot, out_chan.dot_out);
          err_count++;
        end
        if (out_chan.led_out !== e.led) begin
          $error("led_out: expected %b actual %b", e.led, out_chan.led_out);
          err_count++;
        end
        if (out_chan.tube !== e.tube) begin
          $error("tube: expected %0d actual %0d", e.tube, out_chan.tube);
          err_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.op           = OP_TICK;
    in_chan.position     = 2'd0;
    in_chan.char_code    = 8'd0;
    in_chan.number       = 16'd0;
    in_chan.left_justify = 1'b0;
    in_chan.flag         = 1'b0;
    out_chan.ready       = 1'b0;
    err_count            = 0;
    cmd_count            = 0;
    scan_count           = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_left            = 0;
    scan_pos             = 2'd0;
    blank_chars();
    for (int i = 0; i < NUM_TUBES; i++) led_mem[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_writes();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();
    test_backpressure_fill();

    @(negedge clk);
    in_chan.valid  = 1'b0;
    recv_stall_pct = 0;
    waited         = 0;
    while (pending_scans.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_scans.size() != 0) begin
      $error("%0d scan results never arrived", pending_scans.size());
      err_count++;
    end

    $display("Run covered %0d commands: all ops, directed and random, stalls, back-pressure",
             cmd_count);
    $display("Scan results checked: %0d, mismatches: %0d", scan_count, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ vfd_four_digit_scan_driver.f @@
hw/rtl/vfd_pkg.sv
hw/rtl/vfd_if.sv
hw/rtl/vfd_bcd_split.sv
hw/rtl/vfd_display.sv
hw/rtl/vfd_four_digit_scan_driver.sv
bench/tb_top.sv
